// File: src/kruskal_minimum_spanning_tree_assert.svh
`ifndef KRUSKAL_MINIMUM_SPANNING_TREE_ASSERT_SVH
`define KRUSKAL_MINIMUM_SPANNING_TREE_ASSERT_SVH

// same-cycle implication
`define KMST_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmst assertion failed");

// next-cycle implication
`define KMST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmst assertion failed");

`endif

// File: src/kmst_pkg.sv
package kmst_pkg;

  localparam int MaxNodes     = 32;
  localparam int MaxEdges     = 64;
  localparam int WeightBits   = 16;
  localparam int TotalW       = 21;
  localparam int CfgW         = 6;
  localparam int NodeCountRst = 32;
  localparam int DataW        = 32;
  localparam int AddrW        = 3;

  // register index of node_count
  localparam logic RegNodeCount = 1'b0;

endpackage

// File: src/kmst_edge_mem.sv
module kmst_edge_mem #(
  parameter int MAX_NODES   = kmst_pkg::MaxNodes,
  parameter int MAX_EDGES   = kmst_pkg::MaxEdges,
  parameter int WEIGHT_BITS = kmst_pkg::WeightBits,
  localparam int NodeW = $clog2(MAX_NODES),
  localparam int EdgeA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int EdW   = 2 * NodeW + WEIGHT_BITS
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [EdgeA-1:0] waddr_i,
  input  logic [EdW-1:0]   wdata_i,
  input  logic [EdgeA-1:0] raddr_i,
  output logic [EdW-1:0]   rdata_o
);

  logic [EdW-1:0] mem_q [MAX_EDGES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/kmst_uf_mem.sv
module kmst_uf_mem #(
  parameter int MAX_NODES = kmst_pkg::MaxNodes,
  localparam int NodeW = $clog2(MAX_NODES),
  localparam int RankW = $clog2($clog2(MAX_NODES) + 1)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [NodeW-1:0] waddr_i,
  input  logic [NodeW-1:0] wparent_i,
  input  logic [RankW-1:0] wrank_i,
  input  logic [NodeW-1:0] raddr_i,
  output logic [NodeW-1:0] rparent_o,
  output logic [RankW-1:0] rrank_o
);

  logic [NodeW+RankW-1:0] mem_q [MAX_NODES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wparent_i, wrank_i};
    end
    {rparent_o, rrank_o} <= mem_q[raddr_i];
  end

endmodule

// File: src/kruskal_minimum_spanning_tree.sv
// Kruskal minimum spanning tree. Edges are loaded one word per cycle into the
// edge memory; the word flagged last_edge starts the run, during which input
// is stalled. A run first sets up the union-find memory for the n nodes in
// use, then, for every stored edge in weight order, makes a full pass over the
// edge memory through its single read port, walks to the roots of both ends
// and, if they differ, joins them and emits the edge. One word per chosen edge
// is sent, then a total word with last set. Equal weights keep load order.
module kruskal_minimum_spanning_tree #(
  parameter int MAX_NODES   = kmst_pkg::MaxNodes,
  parameter int MAX_EDGES   = kmst_pkg::MaxEdges,
  parameter int WEIGHT_BITS = kmst_pkg::WeightBits,
  localparam int NodeW = $clog2(MAX_NODES),
  localparam int RankW = $clog2($clog2(MAX_NODES) + 1),
  localparam int EdgeA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int CntW  = $clog2(MAX_EDGES + 1),
  localparam int EdW   = 2 * NodeW + WEIGHT_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [kmst_pkg::AddrW-1:0]           paddr,
  input  logic [kmst_pkg::DataW-1:0]           pwdata,
  output logic [kmst_pkg::DataW-1:0]           prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [NodeW-1:0]                     first_node_i,
  input  logic [NodeW-1:0]                     second_node_i,
  input  logic signed [WEIGHT_BITS-1:0]        weight_i,
  input  logic                                 last_edge_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [NodeW-1:0]                     tree_first_node_o,
  output logic [NodeW-1:0]                     tree_second_node_o,
  output logic signed [kmst_pkg::TotalW-1:0]   total_weight_o,
  output logic                                 is_total_o,
  output logic                                 overflow_o,
  output logic                                 last_o
);

  typedef enum logic [3:0] {
    S_LOAD, S_INIT, S_SCAN, S_FA, S_FB, S_UNION, S_UNION2, S_EMIT, S_TOTAL
  } state_e;

  state_e state_q, state_d;

  logic [kmst_pkg::CfgW-1:0] node_count_q, node_count_d;
  logic [CntW-1:0] cnt_q, cnt_d, sel_q, sel_d, rd_q, rd_d;
  logic drop_q, drop_d;
  logic [NodeW:0] init_q, init_d, n_eff;
  logic have_last_q, have_last_d, found_q, found_d, pend_q, pend_d, look_q, look_d;
  logic signed [WEIGHT_BITS-1:0] last_w_q, last_w_d, best_w_q, best_w_d;
  logic [EdgeA-1:0] last_i_q, last_i_d, best_i_q, best_i_d, pend_i_q, pend_i_d;
  logic [NodeW-1:0] best_u_q, best_u_d, best_v_q, best_v_d, walk_q, walk_d;
  logic [NodeW-1:0] root_a_q, root_a_d, root_b_q, root_b_d;
  logic [RankW-1:0] rank_a_q, rank_a_d, rank_b_q, rank_b_d;
  logic signed [kmst_pkg::TotalW-1:0] total_q, total_d;

  logic out_valid_q, out_valid_d, out_total_q, out_total_d, out_ovf_q, out_ovf_d;
  logic [NodeW-1:0] out_u_q, out_u_d, out_v_q, out_v_d;
  logic signed [kmst_pkg::TotalW-1:0] out_sum_q, out_sum_d;

  logic in_acc, cfg_wr, out_free, edge_ok;
  logic em_we;
  logic [EdgeA-1:0] em_waddr, em_raddr;
  logic [EdW-1:0] em_wdata, em_rdata;
  logic [NodeW-1:0] du, dv;
  logic signed [WEIGHT_BITS-1:0] dw;
  logic gt_last, better;
  logic uf_we;
  logic [NodeW-1:0] uf_waddr, uf_wparent, uf_raddr, uf_rparent;
  logic [RankW-1:0] uf_wrank, uf_rrank;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == kmst_pkg::RegNodeCount) ?
                  kmst_pkg::DataW'(node_count_q) : '0;

  assign in_stall_o = (state_q != S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    if (32'(node_count_q) > 32'(MAX_NODES)) begin
      n_eff = (NodeW + 1)'(MAX_NODES);
    end else begin
      n_eff = (NodeW + 1)'(node_count_q);
    end
  end

  assign edge_ok = ((NodeW + 1)'(first_node_i) < n_eff) &&
                   ((NodeW + 1)'(second_node_i) < n_eff) &&
                   (cnt_q != CntW'(MAX_EDGES));

  assign em_we    = in_acc && edge_ok;
  assign em_waddr = cnt_q[EdgeA-1:0];
  assign em_wdata = {first_node_i, second_node_i, weight_i};
  assign em_raddr = rd_q[EdgeA-1:0];
  assign {du, dv, dw} = em_rdata;

  assign gt_last = !have_last_q || (dw > last_w_q) ||
                   ((dw == last_w_q) && (pend_i_q > last_i_q));
  assign better  = !found_q || (dw < best_w_q);

  kmst_edge_mem #(
    .MAX_NODES  (MAX_NODES),
    .MAX_EDGES  (MAX_EDGES),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_edge_mem (
    .clk_i  (clk_i),
    .we_i   (em_we),
    .waddr_i(em_waddr),
    .wdata_i(em_wdata),
    .raddr_i(em_raddr),
    .rdata_o(em_rdata)
  );

  assign uf_raddr = look_q ? uf_rparent : walk_q;

  always_comb begin
    uf_we      = 1'b0;
    uf_waddr   = root_b_q;
    uf_wparent = root_a_q;
    uf_wrank   = rank_b_q;
    case (state_q)
      S_INIT: begin
        uf_we      = (init_q < n_eff);
        uf_waddr   = init_q[NodeW-1:0];
        uf_wparent = init_q[NodeW-1:0];
        uf_wrank   = '0;
      end
      S_UNION: begin
        uf_we = 1'b1;
        if (rank_a_q < rank_b_q) begin
          uf_waddr   = root_a_q;
          uf_wparent = root_b_q;
          uf_wrank   = rank_a_q;
        end
      end
      S_UNION2: begin
        uf_we      = 1'b1;
        uf_waddr   = root_a_q;
        uf_wparent = root_a_q;
        uf_wrank   = rank_a_q + RankW'(1);
      end
      default: begin
        uf_we = 1'b0;
      end
    endcase
  end

  kmst_uf_mem #(
    .MAX_NODES(MAX_NODES)
  ) u_uf_mem (
    .clk_i    (clk_i),
    .we_i     (uf_we),
    .waddr_i  (uf_waddr),
    .wparent_i(uf_wparent),
    .wrank_i  (uf_wrank),
    .raddr_i  (uf_raddr),
    .rparent_o(uf_rparent),
    .rrank_o  (uf_rrank)
  );

  always_comb begin
    state_d      = state_q;
    node_count_d = node_count_q;
    cnt_d        = cnt_q;
    sel_d        = sel_q;
    rd_d         = rd_q;
    drop_d       = drop_q;
    init_d       = init_q;
    have_last_d  = have_last_q;
    found_d      = found_q;
    pend_d       = 1'b0;
    pend_i_d     = pend_i_q;
    look_d       = look_q;
    last_w_d     = last_w_q;
    last_i_d     = last_i_q;
    best_w_d     = best_w_q;
    best_i_d     = best_i_q;
    best_u_d     = best_u_q;
    best_v_d     = best_v_q;
    walk_d       = walk_q;
    root_a_d     = root_a_q;
    root_b_d     = root_b_q;
    rank_a_d     = rank_a_q;
    rank_b_d     = rank_b_q;
    total_d      = total_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_total_d  = out_total_q;
    out_ovf_d    = out_ovf_q;
    out_u_d      = out_u_q;
    out_v_d      = out_v_q;
    out_sum_d    = out_sum_q;

    if (cfg_wr && (paddr[2] == kmst_pkg::RegNodeCount)) begin
      node_count_d = pwdata[kmst_pkg::CfgW-1:0];
    end

    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (edge_ok) begin
            cnt_d = cnt_q + CntW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (last_edge_i) begin
            init_d  = '0;
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        if (init_q >= n_eff) begin
          rd_d        = '0;
          found_d     = 1'b0;
          have_last_d = 1'b0;
          sel_d       = '0;
          state_d     = (cnt_q == '0) ? S_TOTAL : S_SCAN;
        end else begin
          init_d = init_q + (NodeW + 1)'(1);
        end
      end
      S_SCAN: begin
        if (rd_q < cnt_q) begin
          pend_d   = 1'b1;
          pend_i_d = rd_q[EdgeA-1:0];
          rd_d     = rd_q + CntW'(1);
        end
        if (pend_q && gt_last && better) begin
          found_d  = 1'b1;
          best_w_d = dw;
          best_i_d = pend_i_q;
          best_u_d = du;
          best_v_d = dv;
        end
        if ((rd_q == cnt_q) && !pend_q) begin
          have_last_d = 1'b1;
          last_w_d    = best_w_q;
          last_i_d    = best_i_q;
          sel_d       = sel_q + CntW'(1);
          walk_d      = best_u_q;
          look_d      = 1'b0;
          state_d     = S_FA;
        end
      end
      S_FA, S_FB: begin
        if (!look_q) begin
          look_d = 1'b1;
        end else if (uf_rparent == walk_q) begin
          look_d = 1'b0;
          if (state_q == S_FA) begin
            root_a_d = walk_q;
            rank_a_d = uf_rrank;
            walk_d   = best_v_q;
            state_d  = S_FB;
          end else begin
            root_b_d = walk_q;
            rank_b_d = uf_rrank;
            if (walk_q == root_a_q) begin
              rd_d    = '0;
              found_d = 1'b0;
              state_d = (sel_q == cnt_q) ? S_TOTAL : S_SCAN;
            end else begin
              state_d = S_UNION;
            end
          end
        end else begin
          walk_d = uf_rparent;
        end
      end
      S_UNION: begin
        state_d = (rank_a_q == rank_b_q) ? S_UNION2 : S_EMIT;
      end
      S_UNION2: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_total_d = 1'b0;
          out_ovf_d   = 1'b0;
          out_u_d     = best_u_q;
          out_v_d     = best_v_q;
          out_sum_d   = '0;
          total_d     = total_q + kmst_pkg::TotalW'(best_w_q);
          rd_d        = '0;
          found_d     = 1'b0;
          state_d     = (sel_q == cnt_q) ? S_TOTAL : S_SCAN;
        end
      end
      S_TOTAL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_total_d = 1'b1;
          out_ovf_d   = drop_q;
          out_u_d     = '0;
          out_v_d     = '0;
          out_sum_d   = total_q;
          total_d     = '0;
          cnt_d       = '0;
          sel_d       = '0;
          drop_d      = 1'b0;
          state_d     = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      node_count_q <= kmst_pkg::CfgW'(kmst_pkg::NodeCountRst);
      cnt_q        <= '0;
      sel_q        <= '0;
      rd_q         <= '0;
      drop_q       <= 1'b0;
      init_q       <= '0;
      have_last_q  <= 1'b0;
      found_q      <= 1'b0;
      pend_q       <= 1'b0;
      look_q       <= 1'b0;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      node_count_q <= node_count_d;
      cnt_q        <= cnt_d;
      sel_q        <= sel_d;
      rd_q         <= rd_d;
      drop_q       <= drop_d;
      init_q       <= init_d;
      have_last_q  <= have_last_d;
      found_q      <= found_d;
      pend_q       <= pend_d;
      look_q       <= look_d;
      total_q      <= total_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_i_q    <= pend_i_d;
    last_w_q    <= last_w_d;
    last_i_q    <= last_i_d;
    best_w_q    <= best_w_d;
    best_i_q    <= best_i_d;
    best_u_q    <= best_u_d;
    best_v_q    <= best_v_d;
    walk_q      <= walk_d;
    root_a_q    <= root_a_d;
    root_b_q    <= root_b_d;
    rank_a_q    <= rank_a_d;
    rank_b_q    <= rank_b_d;
    out_total_q <= out_total_d;
    out_ovf_q   <= out_ovf_d;
    out_u_q     <= out_u_d;
    out_v_q     <= out_v_d;
    out_sum_q   <= out_sum_d;
  end

  assign out_valid_o        = out_valid_q;
  assign tree_first_node_o  = out_u_q;
  assign tree_second_node_o = out_v_q;
  assign total_weight_o     = out_sum_q;
  assign is_total_o         = out_total_q;
  assign overflow_o         = out_ovf_q;
  assign last_o             = out_total_q;

`include "kruskal_minimum_spanning_tree_assert.svh"

  `KMST_ASSERT_NOW(a_cnt_cap, clk_i, rst_ni, 1'b1, 32'(cnt_q) <= 32'(MAX_EDGES))
  `KMST_ASSERT_NOW(a_sel_le_cnt, clk_i, rst_ni, 1'b1, sel_q <= cnt_q)
  `KMST_ASSERT_NOW(a_union_roots, clk_i, rst_ni, state_q == S_UNION, root_a_q != root_b_q)
  `KMST_ASSERT_NEXT(a_total_clears, clk_i, rst_ni, (state_q == S_TOTAL) && out_free, (state_q == S_LOAD) && (cnt_q == '0) && out_valid_q && is_total_o)

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [4:0]  u;
    logic [4:0]  v;
    logic [20:0] total;
    logic        is_total;
    logic        ovf;
    logic        last;
  } tree_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [kmst_pkg::AddrW-1:0] paddr = '0;
  logic [kmst_pkg::DataW-1:0] pwdata = '0;
  logic [kmst_pkg::DataW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [4:0] first_node_i = '0, second_node_i = '0;
  logic signed [15:0] weight_i = '0;
  logic last_edge_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [4:0] tree_first_node_o, tree_second_node_o;
  logic signed [20:0] total_weight_o;
  logic is_total_o, overflow_o, last_o;

  kruskal_minimum_spanning_tree u_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [4:0]         g_u [kmst_pkg::MaxEdges];
  logic [4:0]         g_v [kmst_pkg::MaxEdges];
  logic signed [15:0] g_w [kmst_pkg::MaxEdges];
  int unsigned        g_count;
  logic               g_dropped;
  logic [5:0]         nodes_in_use = 6'd32;
  logic [4:0]         uf_parent [kmst_pkg::MaxNodes];
  logic [2:0]         uf_rank [kmst_pkg::MaxNodes];

  tree_word_t tree_words_q[$];
  int mismatches = 0;
  int send_idle = 0, recv_idle = 0;
  bit hold_recv = 0;
  int idle_cycles = 0;

  function automatic logic [4:0] uf_root(logic [4:0] x);
    logic [4:0] r, nx;
    r = x;
    while (uf_parent[r] != r) r = uf_parent[r];
    while (uf_parent[x] != r) begin
      nx = uf_parent[x];
      uf_parent[x] = r;
      x = nx;
    end
    return r;
  endfunction

  task automatic predict_mst(input logic [4:0] a, input logic [4:0] b,
                             input logic signed [15:0] w, input logic run);
    int n;
    int ord[$];
    int j;
    logic [4:0] ra, rb;
    logic [20:0] sum;
    tree_word_t t;
    n = (nodes_in_use > 32) ? 32 : nodes_in_use;
    if (a >= n || b >= n || g_count >= kmst_pkg::MaxEdges) g_dropped = 1'b1;
    else begin
      g_u[g_count] = a; g_v[g_count] = b; g_w[g_count] = w;
      g_count++;
    end
    if (!run) return;
    for (int i = 0; i < g_count; i++) begin
      j = ord.size();
      while (j > 0 && g_w[ord[j-1]] > g_w[i]) j--;
      ord.insert(j, i);
    end
    for (int i = 0; i < n; i++) begin
      uf_parent[i] = i; uf_rank[i] = 0;
    end
    sum = '0;
    foreach (ord[i]) begin
      ra = uf_root(g_u[ord[i]]);
      rb = uf_root(g_v[ord[i]]);
      if (ra != rb) begin
        if (uf_rank[ra] > uf_rank[rb]) uf_parent[rb] = ra;
        else if (uf_rank[ra] < uf_rank[rb]) uf_parent[ra] = rb;
        else begin
          uf_parent[rb] = ra; uf_rank[ra]++;
        end
        sum += {{5{g_w[ord[i]][15]}}, g_w[ord[i]]};
        t = '0; t.u = g_u[ord[i]]; t.v = g_v[ord[i]];
        tree_words_q.push_back(t);
      end
    end
    t = '0; t.total = sum; t.is_total = 1; t.ovf = g_dropped; t.last = 1;
    tree_words_q.push_back(t);
    g_count = 0; g_dropped = 0;
  endtask

  // receiver stall
  always @(negedge clk_i) begin
    out_stall_i <= hold_recv || ($urandom_range(99) < recv_idle);
  end

  // result checker
  always @(posedge clk_i) begin
    tree_word_t got, exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {tree_first_node_o, tree_second_node_o, total_weight_o,
             is_total_o, overflow_o, last_o};
      if (tree_words_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        exp_w = tree_words_q.pop_front();
        if (got !== exp_w) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %h got %h", exp_w, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 200000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_node_count(input logic [5:0] val);
    @(negedge clk_i);
    psel <= 1; pwrite <= 1;
    paddr <= kmst_pkg::AddrW'(kmst_pkg::RegNodeCount) << 2;
    pwdata <= kmst_pkg::DataW'(val);
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    nodes_in_use = val;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_edge(input logic [4:0] a, input logic [4:0] b,
                           input logic signed [15:0] w, input logic run);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) @(negedge clk_i);
    in_valid_i <= 1; first_node_i <= a; second_node_i <= b;
    weight_i <= w; last_edge_i <= run;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_mst(a, b, w, run);
    @(negedge clk_i);
    in_valid_i <= 0;
  endtask

  task automatic drain();
    while (tree_words_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic test_directed();
    write_node_count(6'd32);
    send_edge(5'd0, 5'd0, 16'sd0, 1);                // self loop alone
    send_edge(5'd31, 5'd0, -16'sd32768, 0);
    send_edge(5'd0, 5'd31, 16'sd32767, 0);
    send_edge(5'd1, 5'd2, 16'sd5, 0);
    send_edge(5'd2, 5'd1, 16'sd5, 0);                // equal weight tie
    send_edge(5'd3, 5'd31, 16'sd5, 1);
    drain();
    send_edge(5'd0, 5'd0, 16'sd0, 1);                // self loop alone
    drain();
    write_node_count(6'd4);
    send_edge(5'd4, 5'd1, 16'sd1, 0);                // out of range
    send_edge(5'd0, 5'd1, -16'sd7, 0);
    send_edge(5'd2, 5'd3, 16'sd2, 0);
    send_edge(5'd1, 5'd2, 16'sd9, 1);
    drain();
    send_edge(5'd9, 5'd9, 16'sd3, 1);                // dropped last edge, empty run
    drain();
    write_node_count(6'd0);
    send_edge(5'd0, 5'd0, 16'sd1, 1);
    drain();
    write_node_count(6'd63);
    send_edge(5'd31, 5'd30, 16'sd4, 1);
    drain();
    write_node_count(6'd1);
    send_edge(5'd0, 5'd0, -16'sd1, 1);
    drain();
  endtask

  task automatic test_store_full();
    write_node_count(6'd32);
    for (int i = 0; i < 66; i++)
      send_edge(5'($urandom), 5'($urandom), 16'($urandom), i == 65);
    drain();
  endtask

  task automatic test_random_graphs(input int n_edges);
    int left, len;
    logic [5:0] n;
    left = n_edges;
    while (left > 0) begin
      n = 6'($urandom_range(2, 12));
      if ($urandom_range(9) == 0) n = 6'($urandom_range(0, 63));
      write_node_count(n);
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(19) == 0)
          send_edge(5'($urandom), 5'($urandom), 16'($urandom), i == len - 1);
        else
          send_edge(5'($urandom_range(0, (n > 1 && n < 33) ? n - 1 : 0)),
                    5'($urandom_range(0, (n > 1 && n < 33) ? n - 1 : 0)),
                    ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15)),
                    i == len - 1);
      end
      left -= len;
      drain();
    end
  endtask

  task automatic test_backpressure();
    write_node_count(6'd8);
    hold_recv = 1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_recv = 0;
      end
    join_none
    for (int i = 0; i < 12; i++)
      send_edge(5'($urandom_range(7)), 5'($urandom_range(7)), 16'($urandom), i % 4 == 3);
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    test_directed();
    test_store_full();
    send_idle = 12; recv_idle = 72;
    test_random_graphs(50);
    send_idle = 72; recv_idle = 12;
    test_random_graphs(50);
    send_idle = 0; recv_idle = 0;
    test_backpressure();
    test_random_graphs(40);
    drain();
    if (mismatches == 0 && tree_words_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
